// ===== rtl/gmr_pkg.sv =====
// Shared types and constants for the grid maze reachability block.
// No dependencies; imported by every other module of the block.
package gmr_pkg;

   // fixed field widths
   localparam int COORD_W = 6;
   localparam int SIDE_W  = 7;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register index of grid_side
   localparam logic [CSR_AW-3:0] REG_GRID_SIDE = '0;

   // reset value of grid_side
   localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 7'd64;

   // broadcast from the sequencer to every row cell
   typedef struct packed {
      logic               load_en;
      logic [COORD_W-1:0] load_row;
      logic [COORD_W-1:0] load_col;
      logic               load_val;
      logic               clear;
      logic               step;
      logic [SIDE_W-1:0]  side;
      logic [COORD_W-1:0] src_row;
      logic [COORD_W-1:0] src_col;
      logic [COORD_W-1:0] dst_row;
      logic [COORD_W-1:0] dst_col;
   } cell_ctrl_type;

   // status returned by each row cell
   typedef struct packed {
      logic chg;
      logic hit;
   } cell_stat_type;

endpackage

// ===== rtl/gmr_row_cell.sv =====
// One grid row: open bits, reached bits and one wavefront step per cycle while step is high.
// Depends on gmr_pkg; instantiated once per row by grid_maze_reachability.
module gmr_row_cell #(
   parameter int MAX_SIDE = 64,
   parameter int IDX      = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gmr_pkg::cell_ctrl_type ctrl,
   input  logic [MAX_SIDE-1:0]    col_mask,
   input  logic [MAX_SIDE-1:0]    emit_up,
   input  logic [MAX_SIDE-1:0]    emit_down,
   output logic [MAX_SIDE-1:0]    emit_out,
   output gmr_pkg::cell_stat_type stat_out
);
   import gmr_pkg::*;

   localparam int IW = $clog2(MAX_SIDE);

   logic [MAX_SIDE-1:0] open_ff, open_in;
   logic [MAX_SIDE-1:0] reached_ff, reached_in;
   logic                chg_ff, chg_in;
   logic                hit_ff, hit_in;
   logic [MAX_SIDE-1:0] src_vec;
   logic [MAX_SIDE-1:0] live;
   logic [MAX_SIDE-1:0] spread;
   logic                row_in;
   logic [IW-1:0]       ld_idx, src_idx, dst_idx;
   logic                ld_col_ok, src_col_ok, dst_col_ok;

   assign row_in     = 32'(ctrl.side) > IDX;
   assign ld_idx     = IW'(ctrl.load_col);
   assign src_idx    = IW'(ctrl.src_col);
   assign dst_idx    = IW'(ctrl.dst_col);
   assign ld_col_ok  = 32'(ctrl.load_col) < MAX_SIDE;
   assign src_col_ok = 32'(ctrl.src_col) < MAX_SIDE;
   assign dst_col_ok = 32'(ctrl.dst_col) < MAX_SIDE;

   // cells that may be entered: open and inside the grid in use
   assign live = open_ff & col_mask & {MAX_SIDE{row_in}};

   // load write into this row
   always_comb begin
      open_in = open_ff;
      if (ctrl.load_en && (32'(ctrl.load_row) == IDX) && ld_col_ok) begin
         open_in[ld_idx] = ctrl.load_val;
      end
   end

   // start cell acts as a source but is not itself marked
   always_comb begin
      src_vec = '0;
      if ((32'(ctrl.src_row) == IDX) && src_col_ok) begin
         src_vec[src_idx] = 1'b1;
      end
      src_vec = src_vec & live;
   end

   assign emit_out = reached_ff | src_vec;

   // one wavefront step: take from the four neighbors
   assign spread = emit_up | emit_down | (emit_out << 1) | (emit_out >> 1);

   always_comb begin
      reached_in = reached_ff;
      chg_in     = 1'b0;
      if (ctrl.clear) begin
         reached_in = '0;
      end else if (ctrl.step) begin
         reached_in = reached_ff | (spread & live);
         chg_in     = (reached_in != reached_ff);
      end
   end

   // destination probe, registered
   assign hit_in = !ctrl.clear && (32'(ctrl.dst_row) == IDX) && dst_col_ok &&
                   reached_ff[dst_idx];

   always_ff @(posedge clock) begin
      open_ff <= open_in;
      if (reset) begin
         reached_ff <= '0;
         chg_ff     <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         reached_ff <= reached_in;
         chg_ff     <= chg_in;
         hit_ff     <= hit_in;
      end
   end

   assign stat_out.chg = chg_ff;
   assign stat_out.hit = hit_ff;

endmodule

// ===== rtl/gmr_csr.sv =====
// APB-style register file holding grid_side.
// Depends on gmr_pkg; instantiated by grid_maze_reachability.
module gmr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gmr_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [gmr_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [gmr_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output logic [gmr_pkg::SIDE_W-1:0]  grid_side
);
   import gmr_pkg::*;

   logic [SIDE_W-1:0]   side_ff, side_in;
   logic [CSR_AW-3:0]   reg_idx;
   logic                wr_xfer;

   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_pready = 1'b1;
   assign wr_xfer    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write
   always_comb begin
      side_in = side_ff;
      if (wr_xfer && (reg_idx == REG_GRID_SIDE)) begin
         side_in = csr_pwdata[SIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= GRID_SIDE_RST;
      end else begin
         side_ff <= side_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         REG_GRID_SIDE: csr_prdata = {{(CSR_DW-SIDE_W){1'b0}}, side_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign grid_side = side_ff;

endmodule

// ===== rtl/grid_maze_reachability.sv =====
// Top level of the grid maze reachability block: sequencer, csr, row cells.
// Depends on gmr_pkg, gmr_row_cell and gmr_csr.
//
//  channel   ports                          transfer
//  --------  -----------------------------  ---------------------------------
//  request   start, busy, req_*             start high and busy low at edge
//  result    rsp_valid, rsp_reachable       rsp_valid high for one cycle
//  config    csr_psel .. csr_pready         psel, penable, pwrite, pready high
//
// A load does not raise busy; loads may follow back to back.
// A query holds busy while the sequencer passes through ST_WARM and then ST_RUN,
// leaving ST_RUN once a wavefront step no longer changes the reached map; the
// steps taken follow the BFS depth of the reached region. rsp_valid rises as
// busy falls.
// Reset is synchronous; the open map is not cleared and must be loaded.
// The result cannot be stalled; it is shown for exactly one cycle.
module grid_maze_reachability #(
   parameter int MAX_SIDE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [gmr_pkg::COORD_W-1:0] req_row,
   input  logic [gmr_pkg::COORD_W-1:0] req_col,
   input  logic                        req_cell_open,
   input  logic [gmr_pkg::COORD_W-1:0] req_dest_row,
   input  logic [gmr_pkg::COORD_W-1:0] req_dest_col,
   output logic                        rsp_valid,
   output logic                        rsp_reachable,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gmr_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [gmr_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [gmr_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import gmr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WARM,
      ST_RUN
   } state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   logic               rsp_reach_ff;
   logic [COORD_W-1:0] src_row_ff, src_col_ff, dst_row_ff, dst_col_ff;

   logic [SIDE_W-1:0]   grid_side;
   logic                req_xfer;
   logic                chg_any, hit_any;
   cell_ctrl_type       ctrl;
   logic [MAX_SIDE-1:0] col_mask;
   logic [MAX_SIDE-1:0] chg_vec, hit_vec;
   logic [MAX_SIDE-1:0] emit [MAX_SIDE];
   cell_stat_type       stat [MAX_SIDE];

   gmr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .grid_side   (grid_side)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign req_xfer = start && !busy;

   // broadcast to the row cells
   always_comb begin
      ctrl.load_en  = req_xfer && (req_kind == KIND_LOAD);
      ctrl.load_row = req_row;
      ctrl.load_col = req_col;
      ctrl.load_val = req_cell_open;
      ctrl.clear    = req_xfer && (req_kind == KIND_QUERY);
      ctrl.step     = (state_ff != ST_IDLE);
      ctrl.side     = grid_side;
      ctrl.src_row  = src_row_ff;
      ctrl.src_col  = src_col_ff;
      ctrl.dst_row  = dst_row_ff;
      ctrl.dst_col  = dst_col_ff;
   end

   // column limit of the grid in use
   for (genvar c = 0; c < MAX_SIDE; c++) begin : g_mask
      assign col_mask[c] = 32'(grid_side) > c;
   end

   // chain of row cells, each handing its wavefront to both neighbors
   for (genvar r = 0; r < MAX_SIDE; r++) begin : g_row
      logic [MAX_SIDE-1:0] up_w, down_w;
      if (r == 0) begin : g_top
         assign up_w = '0;
      end else begin : g_mid_up
         assign up_w = emit[r-1];
      end
      if (r == MAX_SIDE-1) begin : g_bot
         assign down_w = '0;
      end else begin : g_mid_dn
         assign down_w = emit[r+1];
      end
      gmr_row_cell #(
         .MAX_SIDE (MAX_SIDE),
         .IDX      (r)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .col_mask  (col_mask),
         .emit_up   (up_w),
         .emit_down (down_w),
         .emit_out  (emit[r]),
         .stat_out  (stat[r])
      );
      assign chg_vec[r] = stat[r].chg;
      assign hit_vec[r] = stat[r].hit;
   end

   assign chg_any = |chg_vec;
   assign hit_any = |hit_vec;

   // sequencer and registered result
   always_ff @(posedge clock) begin
      if (req_xfer && (req_kind == KIND_QUERY)) begin
         src_row_ff <= req_row;
         src_col_ff <= req_col;
         dst_row_ff <= req_dest_row;
         dst_col_ff <= req_dest_col;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_reach_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_kind == KIND_QUERY)) begin
                  state_ff <= ST_WARM;
               end
            end
            ST_WARM: begin
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               // no change in the last step: wavefront has settled
               if (!chg_any) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_reach_ff <= hit_any;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reach_ff;

   // a result strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a result is only given once the search has finished
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a query is still running");

   // an accepted query raises busy and holds it from ST_WARM into ST_RUN
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_QUERY)) |=> busy ##1 busy)
      else $error("query accepted but busy not held");

   // a load never starts a search
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_LOAD)) |=> !busy && !rsp_valid)
      else $error("load transfer caused busy or a result");

endmodule

// ===== dv/grid_maze_reachability_tb.sv =====
// Self-checking testbench for grid_maze_reachability: directed table, then random phases.
// Depends on gmr_pkg and the grid_maze_reachability RTL; reachability is predicted by a local
// breadth-first search over a shadow copy of the loaded grid.
module grid_maze_reachability_tb;
   import gmr_pkg::*;

   localparam int MAX_SIDE    = 64;
   localparam int LOAD_SETTLE = 4;    // margin after the last answer before a CSR write
   localparam int END_SETTLE  = 8;
   localparam int RAND_ITEMS  = 900;
   localparam int CALM_ITEMS  = 150;  // tail of the random part runs without sender gaps
   // worst case: over 900 items, each a query walking a tight maze, plus gaps and
   // CSR traffic, taken several times over
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam logic [CSR_AW-1:0] SIDE_ADDR = CSR_AW'({REG_GRID_SIDE, 2'b00});

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               cell_open;
      logic [COORD_W-1:0] dest_row;
      logic [COORD_W-1:0] dest_col;
   } maze_req_type;

   typedef enum logic [1:0] {STEP_SIDE, STEP_LOAD, STEP_QUERY} step_op_type;

   typedef struct packed {
      step_op_type        op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               cell_open;
      logic [COORD_W-1:0] dest_row;
      logic [COORD_W-1:0] dest_col;
      logic [SIDE_W-1:0]  side;
      logic               pinned;
      logic               pinned_val;
   } dir_step_type;

   // op, row, col, open, dest_row, dest_col, side, pinned, pinned answer
   dir_step_type dir_table [25] = '{
      '{STEP_SIDE,   0,  0, 0,  0,  0,   0, 0, 0},
      '{STEP_LOAD,   0,  0, 1, 63, 63,   0, 0, 0},
      '{STEP_QUERY,  0,  0, 1,  0,  0,   0, 1, 0},  // empty grid
      '{STEP_SIDE,   0,  0, 0,  0,  0,   1, 0, 0},
      '{STEP_QUERY,  0,  0, 0,  0,  0,   0, 1, 0},  // lone cell, start not visited
      '{STEP_QUERY,  0,  0, 1,  0,  1,   0, 1, 0},  // destination outside grid
      '{STEP_QUERY, 63, 63, 0,  0,  0,   0, 1, 0},  // start outside grid
      '{STEP_SIDE,   0,  0, 0,  0,  0,   2, 0, 0},
      '{STEP_LOAD,   0,  1, 1, 42, 21,   0, 0, 0},
      '{STEP_LOAD,   1,  0, 0, 21, 42,   0, 0, 0},
      '{STEP_LOAD,   1,  1, 0,  0,  0,   0, 0, 0},
      '{STEP_QUERY,  0,  0, 0,  0,  0,   0, 0, 0},
      '{STEP_QUERY,  0,  0, 0,  1,  1,   0, 1, 0},  // destination blocked
      '{STEP_QUERY,  1,  0, 1,  0,  0,   0, 1, 0},  // start blocked
      '{STEP_QUERY,  0,  0, 0,  0,  1,   0, 0, 0},
      '{STEP_LOAD,   1,  1, 1, 63,  0,   0, 0, 0},
      '{STEP_QUERY,  0,  0, 1,  1,  1,   0, 0, 0},
      '{STEP_LOAD,   0,  1, 0,  0, 63,   0, 0, 0},
      '{STEP_QUERY,  0,  0, 0,  1,  1,   0, 0, 0},
      '{STEP_SIDE,   0,  0, 0,  0,  0, 127, 0, 0},  // clamps to the store size
      '{STEP_LOAD,  63, 63, 1,  0,  0,   0, 0, 0},
      '{STEP_LOAD,  62, 63, 0,  0,  0,   0, 0, 0},
      '{STEP_LOAD,  63, 62, 0,  0,  0,   0, 0, 0},
      '{STEP_QUERY, 63, 63, 1, 63, 63,   0, 1, 0},  // walled-in corner
      '{STEP_QUERY, 63, 63, 0,  0,  0,   0, 0, 0}
   };

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic                req_kind      = KIND_LOAD;
   logic [COORD_W-1:0]  req_row       = '0;
   logic [COORD_W-1:0]  req_col       = '0;
   logic                req_cell_open = 1'b0;
   logic [COORD_W-1:0]  req_dest_row  = '0;
   logic [COORD_W-1:0]  req_dest_col  = '0;
   logic                csr_psel      = 1'b0;
   logic                csr_penable   = 1'b0;
   logic                csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr     = '0;
   logic [CSR_DW-1:0]   csr_pwdata    = '0;
   logic                busy;
   logic                rsp_valid;
   logic                rsp_reachable;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // shadow of the block state
   bit                  open_cells [MAX_SIDE][MAX_SIDE];
   bit                  written_cells [MAX_SIDE][MAX_SIDE];
   logic [SIDE_W-1:0]   side_cfg = GRID_SIDE_RST;
   bit                  reach_q [$];   // predicted answers of queries in flight
   int                  mismatch_count = 0;
   int                  item_count = 0;
   int                  calm_from = 32'h7fff_ffff;
   longint              cycle_count = 0;

   grid_maze_reachability #(.MAX_SIDE(MAX_SIDE)) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_open (req_cell_open),
      .req_dest_row  (req_dest_row),
      .req_dest_col  (req_dest_col),
      .rsp_valid     (rsp_valid),
      .rsp_reachable (rsp_reachable),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #2 clock = ~clock;

   // BFS from the start; the start is only marked if a neighbor leads back to it
   function automatic bit predict_reachable(input int sr, input int sc, input int dr,
                                            input int dc);
      int side;
      int p;
      int r;
      int c;
      int nr;
      int nc;
      int wave [$];
      bit seen [MAX_SIDE][MAX_SIDE];
      int step_r [4] = '{-1, 1, 0, 0};
      int step_c [4] = '{0, 0, -1, 1};
      side = (side_cfg > MAX_SIDE) ? MAX_SIDE : int'(side_cfg);
      if (sr >= side || sc >= side || dr >= side || dc >= side)
         return 1'b0;
      if (!open_cells[sr][sc] || !open_cells[dr][dc])
         return 1'b0;
      wave.push_back(sr * MAX_SIDE + sc);
      while (wave.size() != 0) begin
         p = wave.pop_front();
         r = p / MAX_SIDE;
         c = p % MAX_SIDE;
         for (int k = 0; k < 4; k++) begin
            nr = r + step_r[k];
            nc = c + step_c[k];
            if (nr < 0 || nc < 0 || nr >= side || nc >= side)
               continue;
            if (!open_cells[nr][nc] || seen[nr][nc])
               continue;
            seen[nr][nc] = 1'b1;
            wave.push_back(nr * MAX_SIDE + nc);
         end
      end
      return seen[dr][dc];
   endfunction

   // first never-loaded cell that a query would look at: the endpoints inside the grid
   // and every in-grid neighbor of the region flooded from an open start
   function automatic bit find_unwritten(input int sr, input int sc, input int dr,
                                         input int dc, output int ur, output int uc);
      int side;
      int p;
      int r;
      int c;
      int nr;
      int nc;
      int wave [$];
      bit seen [MAX_SIDE][MAX_SIDE];
      int step_r [4] = '{-1, 1, 0, 0};
      int step_c [4] = '{0, 0, -1, 1};
      side = (side_cfg > MAX_SIDE) ? MAX_SIDE : int'(side_cfg);
      ur   = 0;
      uc   = 0;
      if (dr < side && dc < side && !written_cells[dr][dc]) begin
         ur = dr;
         uc = dc;
         return 1'b1;
      end
      if (sr >= side || sc >= side)
         return 1'b0;
      if (!written_cells[sr][sc]) begin
         ur = sr;
         uc = sc;
         return 1'b1;
      end
      if (!open_cells[sr][sc])
         return 1'b0;
      wave.push_back(sr * MAX_SIDE + sc);
      while (wave.size() != 0) begin
         p = wave.pop_front();
         r = p / MAX_SIDE;
         c = p % MAX_SIDE;
         for (int k = 0; k < 4; k++) begin
            nr = r + step_r[k];
            nc = c + step_c[k];
            if (nr < 0 || nc < 0 || nr >= side || nc >= side)
               continue;
            if (!written_cells[nr][nc]) begin
               ur = nr;
               uc = nc;
               return 1'b1;
            end
            if (!open_cells[nr][nc] || seen[nr][nc])
               continue;
            seen[nr][nc] = 1'b1;
            wave.push_back(nr * MAX_SIDE + nc);
         end
      end
      return 1'b0;
   endfunction

   function automatic maze_req_type make_req(input logic kind, input int row, input int col,
                                             input logic cell_bit, input int drow,
                                             input int dcol);
      maze_req_type it;
      it.kind      = kind;
      it.row       = COORD_W'(row);
      it.col       = COORD_W'(col);
      it.cell_open = cell_bit;
      it.dest_row  = COORD_W'(drow);
      it.dest_col  = COORD_W'(dcol);
      return it;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   // one request transfer; the shadow state is updated at the accepting edge
   task automatic send_item(input maze_req_type it, input int idle_pct, input bit pinned,
                            input bit pinned_val);
      if (item_count < calm_from && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= it.kind;
      req_row       <= it.row;
      req_col       <= it.col;
      req_cell_open <= it.cell_open;
      req_dest_row  <= it.dest_row;
      req_dest_col  <= it.dest_col;
      do @(posedge clock); while (busy !== 1'b0);
      item_count++;
      if (it.kind == KIND_LOAD) begin
         open_cells[it.row][it.col]    = it.cell_open;
         written_cells[it.row][it.col] = 1'b1;
      end else if (pinned)
         reach_q.push_back(pinned_val);
      else
         reach_q.push_back(predict_reachable(it.row, it.col, it.dest_row, it.dest_col));
   endtask

   // stop sending and let every query answer before touching the CSR
   task automatic settle_idle();
      start <= 1'b0;
      while (reach_q.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   // write grid_side with junk in the upper bits, then read it back
   task automatic write_side(input logic [SIDE_W-1:0] val);
      logic [CSR_DW-1:0] word;
      word              = $urandom;
      word[SIDE_W-1:0]  = val;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= SIDE_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      side_cfg = val;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DW'(val))
         report_mismatch($sformatf("grid_side read %0d, wrote %0d", csr_prdata, val));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result checker: one strobe per query, in order
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid === 1'b1) begin
         if (reach_q.size() == 0) begin
            report_mismatch("result transfer with no query pending");
         end else begin
            want = reach_q.pop_front();
            if (rsp_reachable !== want)
               report_mismatch($sformatf("reachable got %b, predicted %b", rsp_reachable, want));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [SIDE_W-1:0] side_val;
      logic [SIDE_W-1:0] side_plan [8] = '{1, 2, 3, 127, 100, 0, 16, 64};
      maze_req_type      it;
      int                eff;
      int                dens;
      int                idle_pct;
      int                phase;
      int                base;
      int                sel;
      int                sr;
      int                sc;
      int                dr;
      int                dc;
      int                ur;
      int                uc;
      int                tries;
      bit                serp;
      bit                cell_bit;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_table[i]) begin
         if (dir_table[i].op == STEP_SIDE) begin
            settle_idle();
            write_side(dir_table[i].side);
         end else begin
            it = make_req((dir_table[i].op == STEP_QUERY) ? KIND_QUERY : KIND_LOAD,
                          dir_table[i].row, dir_table[i].col, dir_table[i].cell_open,
                          dir_table[i].dest_row, dir_table[i].dest_col);
            send_item(it, 25, dir_table[i].pinned, dir_table[i].pinned_val);
         end
      end

      // random phases: set a side, reshape the maze, then query it
      phase     = 0;
      base      = item_count;
      calm_from = base + RAND_ITEMS - CALM_ITEMS;
      while (item_count - base < RAND_ITEMS) begin
         if (phase < 8)
            side_val = side_plan[phase];
         else if ($urandom_range(0, 9) < 7)
            side_val = SIDE_W'($urandom_range(2, 16));
         else
            side_val = SIDE_W'($urandom_range(17, 64));
         settle_idle();
         write_side(side_val);
         eff      = (side_val > MAX_SIDE) ? MAX_SIDE : int'(side_val);
         idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
         dens     = $urandom_range(30, 90);
         serp     = (eff >= 2 && eff <= 16 && $urandom_range(0, 2) == 0);

         // small grids are rewritten whole, large ones in scattered cells
         if (eff <= 16) begin
            for (int r = 0; r < eff; r++) begin
               for (int c = 0; c < eff; c++) begin
                  if (serp)
                     cell_bit = (r % 2 == 0) || (r % 4 == 1 && c == eff - 1) ||
                                (r % 4 == 3 && c == 0);
                  else
                     cell_bit = $urandom_range(0, 99) < dens;
                  send_item(make_req(KIND_LOAD, r, c, cell_bit, $urandom_range(0, 63),
                                     $urandom_range(0, 63)), idle_pct, 1'b0, 1'b0);
               end
            end
         end else begin
            repeat ($urandom_range(40, 120))
               send_item(make_req(KIND_LOAD, $urandom_range(0, eff - 1),
                                  $urandom_range(0, eff - 1), $urandom_range(0, 99) < dens,
                                  $urandom_range(0, 63), $urandom_range(0, 63)),
                         idle_pct, 1'b0, 1'b0);
         end

         repeat ($urandom_range(10, 30)) begin
            // stray loads anywhere in the store, inside the side or not
            if ($urandom_range(0, 99) < 15)
               send_item(make_req(KIND_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 99) < dens, $urandom_range(0, 63),
                                  $urandom_range(0, 63)), idle_pct, 1'b0, 1'b0);
            sel = $urandom_range(0, 99);
            if (sel < 70 && eff > 0) begin
               // mostly open endpoints inside the grid so the search really runs
               tries = 0;
               do begin
                  sr = $urandom_range(0, eff - 1);
                  sc = $urandom_range(0, eff - 1);
                  tries++;
               end while (!open_cells[sr][sc] && tries < 30);
               tries = 0;
               do begin
                  dr = $urandom_range(0, eff - 1);
                  dc = $urandom_range(0, eff - 1);
                  tries++;
               end while (!open_cells[dr][dc] && tries < 30);
               if (sel < 10) begin
                  dr = sr;
                  dc = sc;
               end
            end else begin
               sr = $urandom_range(0, 63);
               sc = $urandom_range(0, 63);
               dr = $urandom_range(0, 63);
               dc = $urandom_range(0, 63);
            end
            // load, mostly as walls, any cell the query would see before it was ever loaded
            while (find_unwritten(sr, sc, dr, dc, ur, uc))
               send_item(make_req(KIND_LOAD, ur, uc, $urandom_range(0, 99) < 25,
                                  $urandom_range(0, 63), $urandom_range(0, 63)),
                         idle_pct, 1'b0, 1'b0);
            send_item(make_req(KIND_QUERY, sr, sc, $urandom_range(0, 1), dr, dc),
                      idle_pct, 1'b0, 1'b0);
         end
         phase++;
      end

      settle_idle();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
